FILE: sv/hrhs_pkg.sv
// package: shared types and constants of the http response header splitter
`timescale 1ns / 1ps
`default_nettype none
package hrhs_pkg;

	localparam int HEADER_CAP = 512;
	localparam int BODY_CAP = 4096;
	localparam int HDR_CNT_W = $clog2(HEADER_CAP);
	localparam int BODY_CNT_W = $clog2(BODY_CAP);
	localparam int BODY_LEN_W = 12;
	localparam int STATUS_W = 16;

	localparam logic [31:0] TERMINATOR = 32'h0D0A0D0A;
	localparam logic [7:0] ASCII_ZERO = 8'h30;
	localparam int OK_STATUS = 200;
	localparam int DIGIT0_POS = 9;
	localparam int DIGIT1_POS = 10;
	localparam int DIGIT2_POS = 11;
	localparam int MIN_STATUS_LEN = 12;
	localparam int TERM_LEN = 4;

	typedef enum logic [1:0] {
		CMD_START = 2'd0,
		CMD_DATA  = 2'd1,
		CMD_CLOSE = 2'd2,
		CMD_ERROR = 2'd3
	} cmd_t;

	typedef enum logic {
		KIND_BODY    = 1'b0,
		KIND_VERDICT = 1'b1
	} kind_t;

endpackage
`default_nettype wire

FILE: sv/hrhs_channels.sv
// interfaces: input item channel and result item channel
`timescale 1ns / 1ps
`default_nettype none
interface hrhs_in_if;
	logic valid;
	logic ready;
	hrhs_pkg::cmd_t cmd;
	logic [7:0] data_byte;

	modport source(output valid, cmd, data_byte, input ready);
	modport sink(input valid, cmd, data_byte, output ready);
endinterface

interface hrhs_out_if;
	logic valid;
	logic ready;
	hrhs_pkg::kind_t kind;
	logic [7:0] body_byte;
	logic [hrhs_pkg::BODY_LEN_W-1:0] body_length;
	logic signed [hrhs_pkg::STATUS_W-1:0] status_code;
	logic accepted;
	logic failed;

	modport source(output valid, kind, body_byte, body_length, status_code, accepted, failed,
		input ready);
	modport sink(input valid, kind, body_byte, body_length, status_code, accepted, failed,
		output ready);
endinterface
`default_nettype wire

FILE: sv/http_response_header_splitter.sv
// top level: splits an http response stream into body bytes and a final verdict
// input accept reaches result valid via the input register, then the result register
// one item per cycle unless stalled; header/body tracking is one register update per byte
// the input stage stalls only while a finished result waits in the result register
// reset: arst_n clears the pipeline valids and all transfer state, same as a start item
`timescale 1ns / 1ps
`default_nettype none
module http_response_header_splitter (
	input wire logic clk,
	input wire logic arst_n,
	hrhs_in_if.sink resp,
	hrhs_out_if.source result
);

	localparam int HW = hrhs_pkg::HDR_CNT_W;
	localparam int BW = hrhs_pkg::BODY_CNT_W;
	localparam int SW = hrhs_pkg::STATUS_W;

	// input register
	logic s1_valid_s1;
	hrhs_pkg::cmd_t cmd_s1;
	logic [7:0] byte_s1;

	// transfer state
	logic [HW-1:0] hdr_cnt_q, hdr_cnt_d;
	logic [31:0] last4_q, last4_d;
	logic [23:0] digits_q, digits_d;
	logic signed [SW-1:0] status_q, status_d;
	logic hdr_done_q, hdr_done_d;
	logic [BW-1:0] body_cnt_q, body_cnt_d;
	logic fin_q, fin_d;

	// result register
	logic out_valid_q;
	hrhs_pkg::kind_t kind_q, kind_d;
	logic [7:0] body_byte_q, body_byte_d;
	logic [hrhs_pkg::BODY_LEN_W-1:0] body_len_q;
	logic signed [SW-1:0] status_out_q;
	logic accepted_q, accepted_d;
	logic failed_q, failed_d;

	logic emit;
	logic out_free;
	logic s1_adv;
	logic signed [SW-1:0] dig0, dig1, dig2;

	assign out_free = !out_valid_q || result.ready;
	assign s1_adv = s1_valid_s1 && out_free;
	assign resp.ready = !s1_valid_s1 || out_free;

	// digit values from the updated digit bytes, each byte unsigned minus ascii zero
	assign dig0 = signed'(SW'(digits_d[23:16])) - signed'(SW'(hrhs_pkg::ASCII_ZERO));
	assign dig1 = signed'(SW'(digits_d[15:8])) - signed'(SW'(hrhs_pkg::ASCII_ZERO));
	assign dig2 = signed'(SW'(digits_d[7:0])) - signed'(SW'(hrhs_pkg::ASCII_ZERO));

	always_comb begin
		hdr_cnt_d = hdr_cnt_q;
		last4_d = last4_q;
		digits_d = digits_q;
		status_d = status_q;
		hdr_done_d = hdr_done_q;
		body_cnt_d = body_cnt_q;
		fin_d = fin_q;
		emit = 1'b0;
		kind_d = hrhs_pkg::KIND_BODY;
		body_byte_d = 8'd0;
		accepted_d = 1'b0;
		failed_d = 1'b0;
		unique case (cmd_s1) inside
			hrhs_pkg::CMD_START: begin
				hdr_cnt_d = '0;
				last4_d = '0;
				digits_d = '0;
				status_d = '0;
				hdr_done_d = 1'b0;
				body_cnt_d = '0;
				fin_d = 1'b0;
			end
			hrhs_pkg::CMD_DATA: begin
				if (!fin_q) begin
					if (!hdr_done_q) begin
						if (hdr_cnt_q < HW'(hrhs_pkg::HEADER_CAP - 1)) begin
							if (hdr_cnt_q == HW'(hrhs_pkg::DIGIT0_POS))
								digits_d[23:16] = byte_s1;
							else if (hdr_cnt_q == HW'(hrhs_pkg::DIGIT1_POS))
								digits_d[15:8] = byte_s1;
							else if (hdr_cnt_q == HW'(hrhs_pkg::DIGIT2_POS))
								digits_d[7:0] = byte_s1;
							last4_d = {last4_q[23:0], byte_s1};
							hdr_cnt_d = hdr_cnt_q + HW'(1);
						end
						if (hdr_cnt_d >= HW'(hrhs_pkg::TERM_LEN)
								&& last4_d == hrhs_pkg::TERMINATOR) begin
							hdr_done_d = 1'b1;
							if (hdr_cnt_d >= HW'(hrhs_pkg::MIN_STATUS_LEN))
								status_d = SW'(dig0 * SW'(100) + dig1 * SW'(10) + dig2);
						end
					end else if (body_cnt_q < BW'(hrhs_pkg::BODY_CAP - 1)) begin
						body_cnt_d = body_cnt_q + BW'(1);
						emit = 1'b1;
						body_byte_d = byte_s1;
					end
				end
			end
			hrhs_pkg::CMD_CLOSE, hrhs_pkg::CMD_ERROR: begin
				if (!fin_q) begin
					fin_d = 1'b1;
					emit = 1'b1;
					kind_d = hrhs_pkg::KIND_VERDICT;
					failed_d = (cmd_s1 == hrhs_pkg::CMD_ERROR);
					accepted_d = (cmd_s1 == hrhs_pkg::CMD_CLOSE)
						&& (status_q == SW'(hrhs_pkg::OK_STATUS));
				end
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (resp.ready) begin
			s1_valid_s1 <= resp.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (resp.valid && resp.ready) begin
			cmd_s1 <= resp.cmd;
			byte_s1 <= resp.data_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_cnt_q <= '0;
			last4_q <= '0;
			digits_q <= '0;
			status_q <= '0;
			hdr_done_q <= 1'b0;
			body_cnt_q <= '0;
			fin_q <= 1'b0;
		end else if (s1_adv) begin
			hdr_cnt_q <= hdr_cnt_d;
			last4_q <= last4_d;
			digits_q <= digits_d;
			status_q <= status_d;
			hdr_done_q <= hdr_done_d;
			body_cnt_q <= body_cnt_d;
			fin_q <= fin_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= s1_adv && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv && emit) begin
			kind_q <= kind_d;
			body_byte_q <= body_byte_d;
			body_len_q <= hrhs_pkg::BODY_LEN_W'(body_cnt_d);
			status_out_q <= status_q;
			accepted_q <= accepted_d;
			failed_q <= failed_d;
		end
	end

	assign result.valid = out_valid_q;
	assign result.kind = kind_q;
	assign result.body_byte = body_byte_q;
	assign result.body_length = body_len_q;
	assign result.status_code = status_out_q;
	assign result.accepted = accepted_q;
	assign result.failed = failed_q;

	// a body byte never carries verdict flags
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && kind_q == hrhs_pkg::KIND_BODY |-> !accepted_q && !failed_q)
		else $error("body item carries verdict flags");

	// an accepted verdict always has status 200 and no error
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && accepted_q |-> status_out_q == SW'(hrhs_pkg::OK_STATUS) && !failed_q)
		else $error("accepted verdict without ok status");

	// body bytes only flow once the header terminator was seen
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && emit && kind_d == hrhs_pkg::KIND_BODY |-> hdr_done_q)
		else $error("body byte before header complete");

	// nothing is emitted after the verdict until a new start
	assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv && fin_q && cmd_s1 != hrhs_pkg::CMD_START |-> !emit)
		else $error("item emitted after transfer finished");

	// counters stay within their caps
	assert property (@(posedge clk) disable iff (!arst_n)
		hdr_cnt_q <= HW'(hrhs_pkg::HEADER_CAP - 1) && body_cnt_q <= BW'(hrhs_pkg::BODY_CAP - 1))
		else $error("counter beyond cap");

endmodule
`default_nettype wire
